### rtl/core/tvmstk_pkg.sv
// tvmstk_pkg: shared types, codes and sizes of the typed vm stack core
// used by tvmstk_front, tvmstk_back and the top level; no dependencies
package tvmstk_pkg;

  localparam int STACK_DEPTH_DEF  = 1024;
  localparam int MARK_DEPTH_DEF   = 256;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int OP_W     = 3;
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 64;
  localparam int DEPTH_W  = 8;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 10;

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_CHK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_ANY  = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_CHK = 3'd3;
  localparam logic [OP_W-1:0] OP_FRAME    = 3'd4;
  localparam logic [OP_W-1:0] OP_LABEL    = 3'd5;

  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LABEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_WRONG = 3'd2,
    ST_NONE  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP_CHK,
    CMD_POP_ANY,
    CMD_PEEK,
    CMD_FRAME,
    CMD_LABEL,
    CMD_BAD_KIND,
    CMD_BAD_OP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   payload;
    logic [DEPTH_W-1:0]  depth;
  } cmd_t;

endpackage

### rtl/core/tvmstk_front.sv
// tvmstk_front: takes input transactions, classifies the op code and
// holds decoded commands in a two-entry queue for the back end; uses tvmstk_pkg
module tvmstk_front
  import tvmstk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [OP_W-1:0]    in_op,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [DATA_W-1:0]  in_payload,
  input  logic [DEPTH_W-1:0] in_depth,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_take
);

  cmd_t                q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  cmd_t                dec;
  logic                enq, deq;

  always_comb begin
    dec.kind    = in_kind;
    dec.payload = in_payload;
    dec.depth   = in_depth;
    case (in_op)
      OP_PUSH:     dec.op = (in_kind == KIND_BAD) ? CMD_BAD_KIND : CMD_PUSH;
      OP_POP_CHK:  dec.op = CMD_POP_CHK;
      OP_POP_ANY:  dec.op = CMD_POP_ANY;
      OP_PEEK_CHK: dec.op = CMD_PEEK;
      OP_FRAME:    dec.op = CMD_FRAME;
      OP_LABEL:    dec.op = CMD_LABEL;
      default:     dec.op = CMD_BAD_OP;
    endcase
  end

  assign in_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign enq       = in_push && !in_full;
  assign deq       = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### rtl/core/tvmstk_back.sv
// tvmstk_back: executes decoded commands against the entry memory and the
// frame and label position memories, and holds one result; uses tvmstk_pkg
module tvmstk_back
  import tvmstk_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_take,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [KIND_W-1:0]   out_read_kind,
  output logic [POS_W-1:0]    out_position
);

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int MIDX_W  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int MCNT_W  = $clog2(MARK_DEPTH + 1);
  localparam int LW      = ((MCNT_W > DEPTH_W) ? MCNT_W : DEPTH_W) + 1;
  localparam int PB      = PAYLOAD_BITS;
  localparam int EW      = KIND_W + PB;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MARK  = 3'b010,
    S_ENTRY = 3'b100
  } state_t;

  logic [EW-1:0]     ent_mem   [STACK_DEPTH];
  logic [IDX_W-1:0]  frame_mem [MARK_DEPTH];
  logic [IDX_W-1:0]  label_mem [MARK_DEPTH];

  state_t             state_r, state_nxt;
  cmd_op_t            op_r, op_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   entry_cnt_r, entry_cnt_nxt;
  logic [MCNT_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [MCNT_W-1:0]  label_cnt_r, label_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [PB-1:0]       out_data_r, out_data_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]    out_pos_r, out_pos_nxt;

  logic [EW-1:0]       ent_rd_q;
  logic [IDX_W-1:0]    frame_rd_q, label_rd_q;

  logic                ent_we, frame_we, label_we;
  logic [IDX_W-1:0]    ent_ra, top_idx, mark_pos;
  logic [MIDX_W-1:0]   frame_ra, label_ra;
  logic [MCNT_W-1:0]   frame_cnt_m1;
  logic [LW-1:0]       lcnt_ext, ldep_ext, lidx_ext;
  logic                lbl_avail, push_full, pop_ok, slot_free;
  logic                res_set;
  status_t             res_status;
  logic [PB-1:0]       res_data;
  logic [KIND_W-1:0]   res_kind;
  logic [IDX_W-1:0]    res_pos;
  logic [KIND_W-1:0]   rd_kind;
  logic [DATA_W+PB-1:0]      data_ext;
  logic [POS_W+IDX_W-1:0]    pos_ext;

  assign top_idx      = IDX_W'(entry_cnt_r - 1'b1);
  assign frame_cnt_m1 = frame_cnt_r - 1'b1;
  assign frame_ra     = frame_cnt_m1[MIDX_W-1:0];
  assign lcnt_ext     = LW'(label_cnt_r);
  assign ldep_ext     = LW'(cmd.depth);
  assign lidx_ext     = lcnt_ext - ldep_ext - 1'b1;
  assign label_ra     = lidx_ext[MIDX_W-1:0];
  assign lbl_avail    = (lcnt_ext > ldep_ext);
  assign mark_pos     = (op_r == CMD_FRAME) ? frame_rd_q : label_rd_q;
  assign rd_kind      = ent_rd_q[EW-1:PB];
  assign pop_ok       = out_pop && out_valid_r;
  assign slot_free    = !out_valid_r || out_pop;
  assign cmd_take     = cmd_valid && (state_r == S_IDLE) && slot_free;
  assign push_full    = (entry_cnt_r == CNT_W'(STACK_DEPTH)) ||
                        ((cmd.kind == KIND_FRAME) && (frame_cnt_r == MCNT_W'(MARK_DEPTH))) ||
                        ((cmd.kind == KIND_LABEL) && (label_cnt_r == MCNT_W'(MARK_DEPTH)));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    entry_cnt_nxt = entry_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    label_cnt_nxt = label_cnt_r;
    ent_we        = 1'b0;
    frame_we      = 1'b0;
    label_we      = 1'b0;
    ent_ra        = top_idx;
    res_set       = 1'b0;
    res_status    = ST_OK;
    res_data      = '0;
    res_kind      = '0;
    res_pos       = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_take) begin
          op_nxt   = cmd.op;
          kind_nxt = cmd.kind;
          case (cmd.op)
            CMD_PUSH: begin
              res_set = 1'b1;
              if (push_full) begin
                res_status = ST_FULL;
              end else begin
                ent_we        = 1'b1;
                entry_cnt_nxt = entry_cnt_r + 1'b1;
                res_kind      = cmd.kind;
                res_pos       = IDX_W'(entry_cnt_r);
                if (cmd.kind == KIND_FRAME) begin
                  frame_we      = 1'b1;
                  frame_cnt_nxt = frame_cnt_r + 1'b1;
                end else if (cmd.kind == KIND_LABEL) begin
                  label_we      = 1'b1;
                  label_cnt_nxt = label_cnt_r + 1'b1;
                end
              end
            end
            CMD_POP_CHK, CMD_POP_ANY, CMD_PEEK: begin
              if (entry_cnt_r == '0) begin
                res_set    = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                pos_nxt   = top_idx;
                state_nxt = S_ENTRY;
              end
            end
            CMD_FRAME: begin
              if (frame_cnt_r == '0) begin
                res_set    = 1'b1;
                res_status = ST_NONE;
              end else begin
                state_nxt = S_MARK;
              end
            end
            CMD_LABEL: begin
              if (!lbl_avail) begin
                res_set    = 1'b1;
                res_status = ST_NONE;
              end else begin
                state_nxt = S_MARK;
              end
            end
            CMD_BAD_KIND: begin
              res_set    = 1'b1;
              res_status = ST_WRONG;
            end
            default: begin
              res_set    = 1'b1;
              res_status = ST_NONE;
            end
          endcase
        end
      end
      S_MARK: begin
        ent_ra    = mark_pos;
        pos_nxt   = mark_pos;
        state_nxt = S_ENTRY;
      end
      S_ENTRY: begin
        res_set   = 1'b1;
        state_nxt = S_IDLE;
        if (((op_r == CMD_POP_CHK) || (op_r == CMD_PEEK)) && (rd_kind != kind_r)) begin
          res_status = ST_WRONG;
        end else begin
          res_data = ent_rd_q[PB-1:0];
          res_kind = rd_kind;
          res_pos  = pos_r;
          if ((op_r == CMD_POP_CHK) || (op_r == CMD_POP_ANY)) begin
            entry_cnt_nxt = entry_cnt_r - 1'b1;
            if ((rd_kind == KIND_FRAME) && (frame_cnt_r != '0)) begin
              frame_cnt_nxt = frame_cnt_r - 1'b1;
            end else if ((rd_kind == KIND_LABEL) && (label_cnt_r != '0)) begin
              label_cnt_nxt = label_cnt_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !pop_ok;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_kind_nxt   = out_kind_r;
    out_pos_nxt    = out_pos_r;
    if (res_set) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_data_nxt   = res_data;
      out_kind_nxt   = res_kind;
      out_pos_nxt    = res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entry_cnt_r <= '0;
      frame_cnt_r <= '0;
      label_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      label_cnt_r <= label_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_kind_r   <= out_kind_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[IDX_W'(entry_cnt_r)] <= {cmd.kind, cmd.payload[PB-1:0]};
    end
    ent_rd_q <= ent_mem[ent_ra];
  end

  // frame position memory
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_cnt_r[MIDX_W-1:0]] <= IDX_W'(entry_cnt_r);
    end
    frame_rd_q <= frame_mem[frame_ra];
  end

  // label position memory
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_cnt_r[MIDX_W-1:0]] <= IDX_W'(entry_cnt_r);
    end
    label_rd_q <= label_mem[label_ra];
  end

  assign data_ext      = {{DATA_W{1'b0}}, out_data_r};
  assign pos_ext       = {{POS_W{1'b0}}, out_pos_r};
  assign out_empty     = !out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = data_ext[DATA_W-1:0];
  assign out_read_kind = out_kind_r;
  assign out_position  = pos_ext[POS_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(entry_cnt_r) <= STACK_DEPTH)
    else $error("entry count above stack depth");

  a_frames_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frame_cnt_r) <= 32'(entry_cnt_r))
    else $error("more frames than entries");

  a_labels_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    32'(label_cnt_r) <= 32'(entry_cnt_r))
    else $error("more labels than entries");

  a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result slot occupied during multi-cycle command");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && (cmd.op == CMD_PUSH) && !push_full) |=>
    (entry_cnt_r == $past(entry_cnt_r) + 1'b1))
    else $error("accepted push did not grow the stack");

endmodule

### rtl/core/typed_vm_stack_with_frame_label_index_core.sv
// typed_vm_stack_with_frame_label_index_core: top level of the typed vm stack
// with frame and label index; instantiates tvmstk_front and tvmstk_back, uses tvmstk_pkg
//
//  channel  dir  handshake          transaction fields
//  in_      in   in_push / in_full  in_op, in_kind, in_payload, in_depth
//  out_     out  out_empty / out_pop out_status, out_read_data, out_read_kind, out_position
//
// transactions pass the command queue, then the back end: push, empty pop and error cases
// finish in S_IDLE, pop and peek add S_ENTRY, frame and label reads S_MARK and S_ENTRY,
// set by the registered reads of the position memories and then of the entry memory
// memories need no clearing pass, reset only clears counts and control
// a full result register stalls the back end; the two-entry queue keeps
// taking transactions until it fills, then in_full rises
module typed_vm_stack_with_frame_label_index_core
  import tvmstk_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [DATA_W-1:0]   in_payload,
  input  logic [DEPTH_W-1:0]  in_depth,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [KIND_W-1:0]   out_read_kind,
  output logic [POS_W-1:0]    out_position
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  tvmstk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_kind    (in_kind),
    .in_payload (in_payload),
    .in_depth   (in_depth),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  tvmstk_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .MARK_DEPTH   (MARK_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .out_read_kind (out_read_kind),
    .out_position  (out_position)
  );

endmodule

### verif/typed_vm_stack_with_frame_label_index_core_test.sv
// testbench for typed_vm_stack_with_frame_label_index_core: directed and random stack
// operations, with a scoreboard class that predicts each transaction's result
// depends on tvmstk_pkg and the core rtl only
module typed_vm_stack_with_frame_label_index_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tvmstk_pkg::*;

  localparam int NUM_ITEMS    = 1650;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [OP_W-1:0]   OP_BAD_LO = 3'd6;
  localparam logic [OP_W-1:0]   OP_BAD_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    pos;
  } reply_t;

  class stack_tracker;
    logic [DATA_W-1:0] payloads [STACK_DEPTH_DEF];
    logic [KIND_W-1:0] kinds [STACK_DEPTH_DEF];
    int                frame_at [MARK_DEPTH_DEF];
    int                label_at [MARK_DEPTH_DEF];
    int                entries;
    int                frames;
    int                labels;
    int                errors;
    reply_t            pending_replies [$];

    function new();
      entries = 0;
      frames  = 0;
      labels  = 0;
      errors  = 0;
    endfunction

    function reply_t entry_reply(int idx);
      reply_t r;
      r.status = ST_OK;
      r.data   = payloads[idx];
      r.kind   = kinds[idx];
      r.pos    = idx[POS_W-1:0];
      return r;
    endfunction

    function void apply_op(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                           logic [DATA_W-1:0] payload, logic [DEPTH_W-1:0] depth);
      reply_t r;
      int     top;
      r = '0;
      r.status = ST_NONE;
      case (op)
        OP_PUSH: begin
          if (kind == KIND_BAD) begin
            r.status = ST_WRONG;
          end else if (entries >= STACK_DEPTH_DEF ||
                       (kind == KIND_FRAME && frames >= MARK_DEPTH_DEF) ||
                       (kind == KIND_LABEL && labels >= MARK_DEPTH_DEF)) begin
            r.status = ST_FULL;
          end else begin
            top = entries;
            payloads[top] = payload;
            kinds[top] = kind;
            entries++;
            if (kind == KIND_FRAME) begin
              frame_at[frames] = top;
              frames++;
            end else if (kind == KIND_LABEL) begin
              label_at[labels] = top;
              labels++;
            end
            r.status = ST_OK;
            r.kind   = kind;
            r.pos    = top[POS_W-1:0];
          end
        end
        OP_POP_CHK, OP_POP_ANY, OP_PEEK_CHK: begin
          if (entries == 0) begin
            r.status = ST_EMPTY;
          end else if (op != OP_POP_ANY && kinds[entries-1] != kind) begin
            r.status = ST_WRONG;
          end else begin
            r = entry_reply(entries - 1);
            if (op != OP_PEEK_CHK) begin
              if (kinds[entries-1] == KIND_FRAME) begin
                frames--;
              end else if (kinds[entries-1] == KIND_LABEL) begin
                labels--;
              end
              entries--;
            end
          end
        end
        OP_FRAME: begin
          if (frames > 0) begin
            r = entry_reply(frame_at[frames-1]);
          end
        end
        OP_LABEL: begin
          if (labels > int'(depth)) begin
            r = entry_reply(label_at[labels - int'(depth) - 1]);
          end
        end
        default: begin
        end
      endcase
      pending_replies = {pending_replies, r};
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void match_result(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none got status %0d",
                 $time, got.status);
        return;
      end
      want = pending_replies.pop_front();
      check_field("status", DATA_W'(want.status), DATA_W'(got.status));
      check_field("read_data", want.data, got.data);
      check_field("read_kind", DATA_W'(want.kind), DATA_W'(got.kind));
      check_field("position", DATA_W'(want.pos), DATA_W'(got.pos));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [OP_W-1:0]     in_op;
  logic [KIND_W-1:0]   in_kind;
  logic [DATA_W-1:0]   in_payload;
  logic [DEPTH_W-1:0]  in_depth;
  logic                out_empty;
  logic                out_pop;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_read_data;
  logic [KIND_W-1:0]   out_read_kind;
  logic [POS_W-1:0]    out_position;

  stack_tracker tracker;
  int           in_quiet = 0;
  int           out_quiet = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;

  typed_vm_stack_with_frame_label_index_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_kind       (in_kind),
    .in_payload    (in_payload),
    .in_depth      (in_depth),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .out_read_kind (out_read_kind),
    .out_position  (out_position)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                         input logic [DATA_W-1:0] payload, input logic [DEPTH_W-1:0] depth);
    int gap;
    gap = pick_gap(in_quiet);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_op      <= op;
    in_kind    <= kind;
    in_payload <= payload;
    in_depth   <= depth;
    do @(posedge clk); while (in_full !== 1'b0);
    tracker.apply_op(op, kind, payload, depth);
    items_sent++;
  endtask

  task automatic send_random(input int push_pct);
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  payload;
    logic [DEPTH_W-1:0] depth;
    int                 r;
    kind    = KIND_W'($urandom_range(0, 2));
    depth   = DEPTH_W'($urandom_range(0, 255));
    payload = {$urandom, $urandom};
    r = $urandom_range(0, 15);
    if (r == 0) payload = '0;
    if (r == 1) payload = '1;
    if ($urandom_range(0, 29) == 0) kind = KIND_BAD;
    if ($urandom_range(0, 99) < push_pct) begin
      op = OP_PUSH;
      // steer away from side stacks that are already full
      if ((kind == KIND_FRAME && tracker.frames >= MARK_DEPTH_DEF ||
           kind == KIND_LABEL && tracker.labels >= MARK_DEPTH_DEF) &&
          $urandom_range(0, 3) != 0) begin
        kind = KIND_VALUE;
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_POP_CHK;
      else if (r < 40) op = OP_POP_ANY;
      else if (r < 55) op = OP_PEEK_CHK;
      else if (r < 70) op = OP_FRAME;
      else if (r < 96) op = OP_LABEL;
      else op = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
      if ((op == OP_POP_CHK || op == OP_PEEK_CHK) && tracker.entries > 0 &&
          $urandom_range(0, 4) != 0) begin
        kind = tracker.kinds[tracker.entries-1];
      end
      if (op == OP_LABEL && tracker.labels > 0 && $urandom_range(0, 4) != 0) begin
        depth = DEPTH_W'($urandom_range(0, tracker.labels - 1));
      end
    end
    send_op(op, kind, payload, depth);
  endtask

  initial begin : result_sink
    reply_t got;
    int     gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = pick_gap(out_quiet);
      repeat (gap) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      got.status = out_status;
      got.data   = out_read_data;
      got.kind   = out_read_kind;
      got.pos    = out_position;
      tracker.match_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tracker    = new();
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_op      = OP_PUSH;
    in_kind    = KIND_FRAME;
    in_payload = '0;
    in_depth   = '0;
    out_pop    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stack cases
    send_op(OP_POP_CHK, KIND_VALUE, '0, '0);
    send_op(OP_POP_ANY, KIND_VALUE, '0, '0);
    send_op(OP_PEEK_CHK, KIND_FRAME, '0, '0);
    send_op(OP_FRAME, KIND_FRAME, '0, '0);
    send_op(OP_LABEL, KIND_LABEL, '0, '0);
    send_op(OP_BAD_LO, KIND_VALUE, '1, '1);
    send_op(OP_BAD_HI, KIND_BAD, '1, '1);
    send_op(OP_PUSH, KIND_BAD, 64'h1234_5678_9abc_def0, '0);
    // frame, label, value, label
    send_op(OP_PUSH, KIND_FRAME, '1, '0);
    send_op(OP_PUSH, KIND_LABEL, '0, '0);
    send_op(OP_PUSH, KIND_VALUE, 64'ha5a5_5a5a_0f0f_f0f0, '0);
    send_op(OP_PUSH, KIND_LABEL, '1, '1);
    send_op(OP_PEEK_CHK, KIND_FRAME, '0, '0);
    send_op(OP_PEEK_CHK, KIND_BAD, '0, '0);
    send_op(OP_PEEK_CHK, KIND_LABEL, '0, '0);
    send_op(OP_FRAME, KIND_FRAME, '0, '0);
    send_op(OP_LABEL, KIND_LABEL, '0, 8'd0);
    send_op(OP_LABEL, KIND_LABEL, '0, 8'd1);
    send_op(OP_LABEL, KIND_LABEL, '0, 8'd2);
    send_op(OP_LABEL, KIND_LABEL, '0, 8'd255);
    send_op(OP_POP_CHK, KIND_VALUE, '0, '0);
    send_op(OP_POP_CHK, KIND_BAD, '0, '0);
    send_op(OP_POP_CHK, KIND_LABEL, '0, '0);
    send_op(OP_POP_ANY, KIND_FRAME, '0, '0);

    repeat (150) send_random(40);

    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);

    // fill to the top, then keep pushing into the full stack
    while (tracker.entries < STACK_DEPTH_DEF && items_sent < 3000) send_random(90);
    repeat (30) send_random(90);
    while (items_sent < NUM_ITEMS) send_random(25);

    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tvmstk_pkg.sv
rtl/core/tvmstk_front.sv
rtl/core/tvmstk_back.sv
rtl/core/typed_vm_stack_with_frame_label_index_core.sv
verif/typed_vm_stack_with_frame_label_index_core_test.sv
